// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the capsule/circle overlap RTL.
// Every macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ccov_pkg.sv =====
// Package for the capsule/circle overlap pipeline: widths, constants and
// the structs that travel between the front, divider and back stages.
`timescale 1ns / 1ps

package ccov_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 16;
  localparam int RAD_W   = 15;
  localparam int REACH_W = RAD_W + 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int LEN_W   = PROD_W - 1;
  localparam int DOT_W   = PROD_W;
  localparam int T_W     = FRAC_W + 1;
  localparam int PT_W    = DIFF_W + T_W + 1;
  localparam int EX_W    = PT_W + 1;
  localparam int RND_SH  = FRAC_W - 4;
  localparam int D8_W    = DIFF_W + 6;
  localparam int SQ_W    = 2 * D8_W;
  localparam int RSQ_W   = 2 * REACH_W;
  localparam int DIST_W  = 34;
  localparam int DIST_SH = 8;

  typedef struct packed {
    logic signed [DIFF_W-1:0] rx;
    logic signed [DIFF_W-1:0] ry;
    logic signed [DIFF_W-1:0] sx;
    logic signed [DIFF_W-1:0] sy;
    logic [REACH_W-1:0]       reach;
  } geom_t;

  typedef struct packed {
    logic degen;
    logic neg;
    logic sat;
  } flag_t;

  typedef struct packed {
    geom_t             g;
    flag_t             f;
    logic [LEN_W-1:0]  len_sq;
    logic [LEN_W-1:0]  rem;
    logic [FRAC_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic              overlap;
    logic [DIST_W-1:0] dist_sq;
    logic              degen;
  } res_t;

endpackage

// ===== rtl/capsule_circle_overlap.sv =====
// Capsule versus circle overlap test, top level.
// Channels: in_* takes one circle/capsule pair per transfer (signed Q11.4
//   coordinates, unsigned Q11.4 half width and radius); out_* gives one
//   result per pair: overlap flag, squared distance in Q26.8, degenerate
//   flag for a zero-length segment. Both use valid/ready.
// Stages: front stages, a 16 stage restoring divider for the projection
//   fraction, back stages, then the two-entry output register.
// Throughput: one pair per cycle while the output is not stalled; every stage is registered.
// Reset: synchronous, active low; clears all valid bits and the ready
//   register; in_ready is low during reset and comes up in the cycle after its release.
// Stall: the output has two entries. While out_ready is low the pipeline
//   keeps running until the second entry fills; in_ready drops in the same
//   cycle and the whole pipeline holds, nothing lost or repeated.
// Depends on ccov_pkg, ccov_front, ccov_div and ccov_back.
`timescale 1ns / 1ps

module capsule_circle_overlap (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ccov_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [ccov_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [ccov_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [ccov_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [ccov_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [ccov_pkg::COORD_W-1:0] in_end_y,
  input  logic [ccov_pkg::RAD_W-1:0]          in_half_width,
  input  logic [ccov_pkg::RAD_W-1:0]          in_circle_rad,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_overlap,
  output logic [ccov_pkg::DIST_W-1:0]         out_distance_sq,
  output logic                                out_degenerate
);

  logic           adv;
  logic           d_valid, q_valid;
  ccov_pkg::div_t d_w, q_w;
  ccov_pkg::res_t res_w;

  ccov_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .pt_x     (in_point_x),
    .pt_y     (in_point_y),
    .a_x      (in_start_x),
    .a_y      (in_start_y),
    .b_x      (in_end_x),
    .b_y      (in_end_y),
    .hw       (in_half_width),
    .cr       (in_circle_rad),
    .d_valid  (d_valid),
    .d_o      (d_w)
  );

  ccov_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .d_valid (d_valid),
    .d_i     (d_w),
    .q_valid (q_valid),
    .q_o     (q_w)
  );

  ccov_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_i       (q_w),
    .out_ready (out_ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_o     (res_w)
  );

  assign in_ready        = adv;
  assign out_overlap     = res_w.overlap;
  assign out_distance_sq = res_w.dist_sq;
  assign out_degenerate  = res_w.degen;

endmodule

// ===== rtl/ccov_front.sv =====
// Front stages: offsets, products, dot and squared length, classification.
// Depends on ccov_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccov_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic signed [ccov_pkg::COORD_W-1:0]  pt_x,
  input  logic signed [ccov_pkg::COORD_W-1:0]  pt_y,
  input  logic signed [ccov_pkg::COORD_W-1:0]  a_x,
  input  logic signed [ccov_pkg::COORD_W-1:0]  a_y,
  input  logic signed [ccov_pkg::COORD_W-1:0]  b_x,
  input  logic signed [ccov_pkg::COORD_W-1:0]  b_y,
  input  logic [ccov_pkg::RAD_W-1:0]           hw,
  input  logic [ccov_pkg::RAD_W-1:0]           cr,
  output logic                                 d_valid,
  output ccov_pkg::div_t                       d_o
);

  localparam int DW = ccov_pkg::DIFF_W;
  localparam int RW = ccov_pkg::REACH_W;
  localparam int LW = ccov_pkg::LEN_W;

  typedef struct packed {
    ccov_pkg::geom_t                      g;
    logic signed [ccov_pkg::PROD_W-1:0]   ssx;
    logic signed [ccov_pkg::PROD_W-1:0]   ssy;
    logic signed [ccov_pkg::PROD_W-1:0]   rxs;
    logic signed [ccov_pkg::PROD_W-1:0]   rys;
  } prod_t;

  typedef struct packed {
    ccov_pkg::geom_t                     g;
    logic [ccov_pkg::LEN_W-1:0]          len_sq;
    logic signed [ccov_pkg::DOT_W-1:0]   dot;
  } sum_t;

  logic [3:0]      v_r, v_nxt;
  ccov_pkg::geom_t f1_r, f1_nxt;
  prod_t           f2_r, f2_nxt;
  sum_t            f3_r, f3_nxt;
  ccov_pkg::div_t  f4_r, f4_nxt;

  always_comb begin
    v_nxt = {v_r[2:0], in_valid};

    f1_nxt.rx    = DW'(pt_x) - DW'(a_x);
    f1_nxt.ry    = DW'(pt_y) - DW'(a_y);
    f1_nxt.sx    = DW'(b_x) - DW'(a_x);
    f1_nxt.sy    = DW'(b_y) - DW'(a_y);
    f1_nxt.reach = RW'(hw) + RW'(cr);

    f2_nxt.g   = f1_r;
    f2_nxt.ssx = f1_r.sx * f1_r.sx;
    f2_nxt.ssy = f1_r.sy * f1_r.sy;
    f2_nxt.rxs = f1_r.rx * f1_r.sx;
    f2_nxt.rys = f1_r.ry * f1_r.sy;

    f3_nxt.g      = f2_r.g;
    f3_nxt.len_sq = LW'(f2_r.ssx + f2_r.ssy);
    f3_nxt.dot    = f2_r.rxs + f2_r.rys;

    f4_nxt.g       = f3_r.g;
    f4_nxt.len_sq  = f3_r.len_sq;
    f4_nxt.q       = '0;
    f4_nxt.f.degen = (f3_r.len_sq == '0);
    f4_nxt.f.neg   = f3_r.dot[ccov_pkg::DOT_W-1] || (f3_r.dot == '0);
    f4_nxt.f.sat   = !f4_nxt.f.neg && ($unsigned(f3_r.dot) >= {1'b0, f3_r.len_sq});
    // seed the divider only when the quotient lies strictly inside (0,1)
    f4_nxt.rem     = (f4_nxt.f.neg || f4_nxt.f.sat) ? '0 : f3_r.dot[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
      f4_r <= f4_nxt;
    end
  end

  assign d_valid = v_r[3];
  assign d_o     = f4_r;

  `ASSERT_ALWAYS(a_degen_neg, (v_r[3] && f4_r.f.degen) |-> f4_r.f.neg, "degenerate pair not zero t")

endmodule

// ===== rtl/ccov_div.sv =====
// Pipelined restoring divider: one quotient bit of dot * 2^FRAC_W / len_sq
// per stage. Depends on ccov_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccov_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           d_valid,
  input  ccov_pkg::div_t d_i,
  output logic           q_valid,
  output ccov_pkg::div_t q_o
);

  localparam int N  = ccov_pkg::FRAC_W;
  localparam int LW = ccov_pkg::LEN_W;

  logic [N-1:0]   v_r, v_nxt;
  ccov_pkg::div_t stg_r   [N];
  ccov_pkg::div_t stg_nxt [N];

  function automatic ccov_pkg::div_t div_step(ccov_pkg::div_t s);
    ccov_pkg::div_t o;
    logic [LW:0]    rem2;
    logic           ge;
    o    = s;
    rem2 = {s.rem, 1'b0};
    ge   = (rem2 >= {1'b0, s.len_sq});
    o.rem = ge ? LW'(rem2 - {1'b0, s.len_sq}) : LW'(rem2);
    o.q   = {s.q[N-2:0], ge};
    return o;
  endfunction

  always_comb begin
    v_nxt      = {v_r[N-2:0], d_valid};
    stg_nxt[0] = div_step(d_i);
    for (int i = 1; i < N; i++) begin
      stg_nxt[i] = div_step(stg_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign q_valid = v_r[N-1];
  assign q_o     = stg_r[N-1];

  `ASSERT_ALWAYS(a_rem_below, (v_r[N-1] && !stg_r[N-1].f.neg) |-> (stg_r[N-1].rem < stg_r[N-1].len_sq), "divider remainder not below divisor")

endmodule

// ===== rtl/ccov_back.sv =====
// Back stages: closest point offsets, squares, sum and reach compare, then
// a two-entry output register. Depends on ccov_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccov_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ccov_pkg::div_t q_i,
  input  logic           out_ready,
  output logic           adv,
  output logic           out_valid,
  output ccov_pkg::res_t out_o
);

  localparam int TW = ccov_pkg::T_W;
  localparam int EW = ccov_pkg::EX_W;
  localparam int DW = ccov_pkg::D8_W;
  localparam int SW = ccov_pkg::SQ_W;
  localparam int FW = ccov_pkg::FRAC_W;
  localparam int SH = ccov_pkg::RND_SH;
  localparam int DS = ccov_pkg::DIST_SH;
  localparam logic [TW-1:0] ONE_T = TW'(1) << FW;
  localparam logic [EW-1:0] RND   = EW'(1) << (SH - 1);
  localparam logic [SW-1:0] DRND  = SW'(1) << (DS - 1);

  typedef struct packed {
    logic signed [ccov_pkg::DIFF_W-1:0] rx;
    logic signed [ccov_pkg::DIFF_W-1:0] ry;
    logic signed [ccov_pkg::PT_W-1:0]   px;
    logic signed [ccov_pkg::PT_W-1:0]   py;
    logic [ccov_pkg::REACH_W-1:0]       reach;
    logic                               degen;
  } b1_t;

  typedef struct packed {
    logic signed [ccov_pkg::D8_W-1:0] dx8;
    logic signed [ccov_pkg::D8_W-1:0] dy8;
    logic [ccov_pkg::REACH_W-1:0]     reach;
    logic                             degen;
  } b2_t;

  typedef struct packed {
    logic [ccov_pkg::SQ_W-1:0]  sqx;
    logic [ccov_pkg::SQ_W-1:0]  sqy;
    logic [ccov_pkg::RSQ_W-1:0] reach_sq;
    logic                       degen;
  } b3_t;

  logic [2:0]        v_r, v_nxt;
  b1_t               b1_r, b1_nxt;
  b2_t               b2_r, b2_nxt;
  b3_t               b3_r, b3_nxt;
  ccov_pkg::res_t    res;
  ccov_pkg::res_t    out_r, out_nxt;
  ccov_pkg::res_t    skid_r, skid_nxt;
  logic              out_v_r, out_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  logic              rdy_r, rdy_nxt;
  logic              take;
  logic [TW-1:0]     t;
  logic signed [TW:0] t_s;
  logic signed [EW-1:0] ex, ey, exr, eyr;
  logic signed [ccov_pkg::SQ_W-1:0] sqx_s, sqy_s;
  logic [SW-1:0]     dsq, dsr;

  always_comb begin
    v_nxt = {v_r[1:0], q_valid};

    if (q_i.f.neg) begin
      t = '0;
    end else if (q_i.f.sat) begin
      t = ONE_T;
    end else begin
      t = {1'b0, q_i.q};
    end
    t_s          = $signed({1'b0, t});
    b1_nxt.rx    = q_i.g.rx;
    b1_nxt.ry    = q_i.g.ry;
    b1_nxt.px    = q_i.g.sx * t_s;
    b1_nxt.py    = q_i.g.sy * t_s;
    b1_nxt.reach = q_i.g.reach;
    b1_nxt.degen = q_i.f.degen;

    // offset to the closest point, rounded half up to Q.8
    ex           = (EW'(b1_r.rx) <<< FW) - EW'(b1_r.px);
    ey           = (EW'(b1_r.ry) <<< FW) - EW'(b1_r.py);
    exr          = ex + $signed(RND);
    eyr          = ey + $signed(RND);
    b2_nxt.dx8   = exr[SH +: DW];
    b2_nxt.dy8   = eyr[SH +: DW];
    b2_nxt.reach = b1_r.reach;
    b2_nxt.degen = b1_r.degen;

    sqx_s           = b2_r.dx8 * b2_r.dx8;
    sqy_s           = b2_r.dy8 * b2_r.dy8;
    b3_nxt.sqx      = $unsigned(sqx_s);
    b3_nxt.sqy      = $unsigned(sqy_s);
    b3_nxt.reach_sq = b2_r.reach * b2_r.reach;
    b3_nxt.degen    = b2_r.degen;

    dsq         = b3_r.sqx + b3_r.sqy;
    dsr         = dsq + DRND;
    res.overlap = (dsq < (SW'(b3_r.reach_sq) << DS));
    res.dist_sq = dsr[DS +: ccov_pkg::DIST_W];
    res.degen   = b3_r.degen;
  end

  // two-entry output: take a new result while the current one waits
  always_comb begin
    take       = out_v_r && out_ready;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else begin
      if (take) begin
        out_v_nxt = 1'b0;
      end
      if (rdy_r && v_r[2]) begin
        if (!out_v_r || take) begin
          out_nxt   = res;
          out_v_nxt = 1'b1;
        end else begin
          skid_nxt   = res;
          skid_v_nxt = 1'b1;
        end
      end
    end
    rdy_nxt = !skid_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
      rdy_r    <= 1'b0;
    end else begin
      if (rdy_r) begin
        v_r <= v_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
      rdy_r    <= rdy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_r) begin
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
      b3_r <= b3_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign adv       = rdy_r;
  assign out_valid = out_v_r;
  assign out_o     = out_r;

  `ASSERT_ALWAYS(a_skid_out, skid_v_r |-> out_v_r, "skid entry full while output empty")
  `ASSERT_ALWAYS(a_rdy_skid, rdy_r |-> !skid_v_r, "pipeline advancing with skid entry full")
  `ASSERT_NEXT(a_skid_hold, skid_v_r && !out_ready, skid_v_r, "skid entry dropped during stall")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for capsule_circle_overlap: directed and random
// circle/capsule pairs, random valid gaps and ready stalls, in-order checks.
// Depends on ccov_pkg and the capsule_circle_overlap RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int  COORD_W   = ccov_pkg::COORD_W;
  localparam int  RAD_W     = ccov_pkg::RAD_W;
  localparam int  FRAC_W    = ccov_pkg::FRAC_W;
  localparam int  DIST_W    = ccov_pkg::DIST_W;
  localparam int  DIST_SH   = ccov_pkg::DIST_SH;
  localparam int  LATENCY   = 23;
  localparam int  RAND_PAIRS = 500;
  localparam int  CYCLE_LIMIT = 400000;
  localparam longint T_ONE  = longint'(1) << FRAC_W;
  localparam int  OFS_SH    = FRAC_W - 4;
  localparam longint OFS_HALF = longint'(1) << (OFS_SH - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [RAD_W-1:0]          half_width;
    logic [RAD_W-1:0]          circle_rad;
  } pair_t;

  typedef struct packed {
    logic              overlap;
    logic [DIST_W-1:0] distance_sq;
    logic              degenerate;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_start_x = '0;
  logic signed [COORD_W-1:0] in_start_y = '0;
  logic signed [COORD_W-1:0] in_end_x = '0;
  logic signed [COORD_W-1:0] in_end_y = '0;
  logic [RAD_W-1:0] in_half_width = '0;
  logic [RAD_W-1:0] in_circle_rad = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_overlap;
  logic [DIST_W-1:0] out_distance_sq;
  logic out_degenerate;

  pair_t    pending_pairs[$];
  verdict_t expected_verdicts[$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       pair_taken = 1'b0;
  int       gap_left = 0;
  int       send_quiet = 0;
  int       stall_left = 0;
  int       recv_quiet = 0;

  capsule_circle_overlap u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_half_width   (in_half_width),
    .in_circle_rad   (in_circle_rad),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_overlap     (out_overlap),
    .out_distance_sq (out_distance_sq),
    .out_degenerate  (out_degenerate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic verdict_t predict_overlap(pair_t p);
    longint px, py, ax, ay, bx, by, sx, sy, rx, ry;
    longint len_sq, dot, t, ex, ey, dx8, dy8, dsq16, reach, reach16;
    verdict_t v;
    px = p.point_x;
    py = p.point_y;
    ax = p.start_x;
    ay = p.start_y;
    bx = p.end_x;
    by = p.end_y;
    sx = bx - ax;
    sy = by - ay;
    rx = px - ax;
    ry = py - ay;
    len_sq = sx * sx + sy * sy;
    if (len_sq == 0) begin
      dx8 = rx * 16;
      dy8 = ry * 16;
    end else begin
      dot = rx * sx + ry * sy;
      if (dot <= 0) t = 0;
      else if (dot >= len_sq) t = T_ONE;
      else t = (dot <<< FRAC_W) / len_sq;
      ex = rx * T_ONE - sx * t;
      ey = ry * T_ONE - sy * t;
      dx8 = (ex + OFS_HALF) >>> OFS_SH;
      dy8 = (ey + OFS_HALF) >>> OFS_SH;
    end
    dsq16 = dx8 * dx8 + dy8 * dy8;
    reach = longint'(p.half_width) + longint'(p.circle_rad);
    reach16 = (reach * reach) <<< DIST_SH;
    v.overlap = (dsq16 < reach16);
    v.distance_sq = DIST_W'((dsq16 + 128) >>> DIST_SH);
    v.degenerate = (len_sq == 0);
    return v;
  endfunction

  function automatic pair_t make_pair(int px, int py, int ax, int ay, int bx, int by,
                                      int hw, int cr);
    pair_t p;
    p.point_x = px[COORD_W-1:0];
    p.point_y = py[COORD_W-1:0];
    p.start_x = ax[COORD_W-1:0];
    p.start_y = ay[COORD_W-1:0];
    p.end_x = bx[COORD_W-1:0];
    p.end_y = by[COORD_W-1:0];
    p.half_width = hw[RAD_W-1:0];
    p.circle_rad = cr[RAD_W-1:0];
    return p;
  endfunction

  function automatic int span(int k);
    return int'($urandom_range(0, (2 << k) - 1)) - (1 << k);
  endfunction

  function automatic pair_t random_pair();
    int mode, k, ax, ay, bx, by, px, py, d, len, hw, cr;
    pair_t p;
    logic [127:0] raw;
    mode = $urandom_range(0, 9);
    k = $urandom_range(3, 13);
    ax = span(k);
    ay = span(k);
    bx = span(k);
    by = span(k);
    px = span(k);
    py = span(k);
    hw = $urandom_range(0, 1 << k);
    cr = $urandom_range(0, 1 << k);
    case (mode)
      0, 1: begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(pair_t)-1:0];
        if ($urandom_range(0, 1)) begin
          p.half_width = RAD_W'($urandom_range(0, 255));
          p.circle_rad = RAD_W'($urandom_range(0, 255));
        end
        return p;
      end
      7: begin
        bx = ax;
        by = ay;
      end
      8: begin
        d = $urandom_range(0, 16);
        px = ax + ((bx - ax) * d) / 16 + span(2);
        py = ay + ((by - ay) * d) / 16 + span(2);
        hw = $urandom_range(0, 8);
        cr = $urandom_range(0, 8);
      end
      9: begin
        len = $urandom_range(0, 4096);
        d = $urandom_range(0, 2000);
        bx = ax + len;
        by = ay;
        px = ax + int'($urandom_range(0, len));
        py = $urandom_range(0, 1) ? ay + d : ay - d;
        hw = $urandom_range(0, d);
        cr = d - hw + int'($urandom_range(0, 2)) - 1;
        if (cr < 0) cr = 0;
        if ($urandom_range(0, 1)) begin
          {ax, ay, bx, by, px, py} = {ay, ax, by, bx, py, px};
        end
      end
      default: ;
    endcase
    return make_pair(px, py, ax, ay, bx, by, hw, cr);
  endfunction

  function automatic int pick_gap(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet = $urandom_range(20, 40);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input driver: hold until transfer, then advance after a random gap.
  always @(negedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pair_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        p = pending_pairs.pop_front();
        in_point_x <= p.point_x;
        in_point_y <= p.point_y;
        in_start_x <= p.start_x;
        in_start_y <= p.start_y;
        in_end_x <= p.end_x;
        in_end_y <= p.end_y;
        in_half_width <= p.half_width;
        in_circle_rad <= p.circle_rad;
        in_valid <= 1'b1;
        gap_left = pick_gap(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
    pair_taken = 1'b0;
  end

  // Result side backpressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap(recv_quiet);
    end
  end

  // Monitor: predict on input transfer, check on result transfer.
  always @(posedge clk) begin
    verdict_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL capsule_circle_overlap");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      expected_verdicts.push_back(predict_overlap({in_point_x, in_point_y, in_start_x,
                                                  in_start_y, in_end_x, in_end_y,
                                                  in_half_width, in_circle_rad}));
      pair_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: overlap=%0b distance_sq=%0d degenerate=%0b",
               out_overlap, out_distance_sq, out_degenerate);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_overlap !== want.overlap) begin
          $error("overlap: expected %0b, got %0b", want.overlap, out_overlap);
          error_count++;
        end
        if (out_distance_sq !== want.distance_sq) begin
          $error("distance_sq: expected %0d, got %0d", want.distance_sq, out_distance_sq);
          error_count++;
        end
        if (out_degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, out_degenerate);
          error_count++;
        end
      end
    end
  end

  initial begin
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767, 32767, -32768, 32767,
                                      32767));
    pending_pairs.push_back(make_pair(32767, -32768, -32768, -32768, 32767, 32767, 32767,
                                      32767));
    pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768, -32768, -32767, 32767,
                                      32767));
    pending_pairs.push_back(make_pair(-300, 400, 100, -200, 100, -200, 200, 300));
    pending_pairs.push_back(make_pair(-80, 48, 0, 0, 160, 0, 40, 40));
    pending_pairs.push_back(make_pair(320, 48, 0, 0, 160, 0, 40, 40));
    pending_pairs.push_back(make_pair(80, 48, 0, 0, 160, 0, 40, 7));
    pending_pairs.push_back(make_pair(0, 32, -160, 0, 160, 0, 16, 16));
    pending_pairs.push_back(make_pair(0, 32, -160, 0, 160, 0, 16, 17));
    pending_pairs.push_back(make_pair(0, -32, 160, 0, -160, 0, 15, 16));
    pending_pairs.push_back(make_pair(50, 0, 0, 0, 160, 0, 0, 0));
    pending_pairs.push_back(make_pair(50, 0, 0, 0, 160, 0, 0, 1));
    pending_pairs.push_back(make_pair(5, 1, 0, 0, 3, 7, 3, 2));
    pending_pairs.push_back(make_pair(160, 30, 0, 0, 160, 0, 10, 10));
    pending_pairs.push_back(make_pair(0, 30, 0, 0, 160, 0, 10, 10));
    pending_pairs.push_back(make_pair(-2000, 100, -1000, 500, -3000, -2500, 500, 700));
    pending_pairs.push_back(make_pair(1, 1, 0, 0, 3, 0, 1, 0));
    pending_pairs.push_back(make_pair(7, -3, 0, 0, 1, 1, 32767, 0));
    pending_pairs.push_back(make_pair(-7, 3, 0, 0, -1, 1, 0, 32767));
    repeat (RAND_PAIRS) pending_pairs.push_back(random_pair());

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("%0d results never arrived", expected_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS capsule_circle_overlap");
    end else begin
      $display("FAIL capsule_circle_overlap");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ccov_pkg.sv
rtl/ccov_front.sv
rtl/ccov_div.sv
rtl/ccov_back.sv
rtl/capsule_circle_overlap.sv
verif/testbench.sv
